### rtl/eld_pkg.sv
`timescale 1ns / 1ps

package eld_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned LevelW    = $clog2(FifoDepth + 1);

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_OCT_LO = 8'h30;
  localparam logic [7:0] CH_OCT_HI = 8'h37;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_V  = 8'h76;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_BODY = 6'b000010,
    PH_ESC  = 6'b000100,
    PH_OCT1 = 6'b001000,
    PH_OCT2 = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
    logic       literal_kind;
  } in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [7:0]         out_byte;
    logic signed [31:0] packed_value;
    logic               multi_char;
    logic               last;
  } res_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  octal_acc;
    logic        char_mode;
    logic [31:0] packed_acc;
    logic        seen_char;
    logic        multi_flag;
  } state_t;

  // decoder to queue: next state plus up to two results
  typedef struct packed {
    state_t     nxt;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } dec_out_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
  } fifo_stat_t;

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= CH_OCT_LO) && (c <= CH_OCT_HI);
  endfunction

  // pack one decoded byte into a character constant
  function automatic state_t emit_upd(input state_t st, input logic [7:0] b);
    state_t s;
    s = st;
    if (s.char_mode) begin
      s.packed_acc = {s.packed_acc[23:0], 8'h00} + {{24{b[7]}}, b};
      if (s.seen_char) begin
        s.multi_flag = 1'b1;
      end
      s.seen_char = 1'b1;
    end
    return s;
  endfunction

  function automatic res_t mk_res(input state_t st, input logic [1:0] kind,
                                  input logic [7:0] b);
    res_t r;
    r.result_kind  = kind;
    r.out_byte     = (kind == KIND_BYTE) ? b : 8'h00;
    r.packed_value = st.char_mode ? $signed(st.packed_acc) : 32'sd0;
    r.multi_char   = st.char_mode ? st.multi_flag : 1'b0;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

### rtl/eld_decode.sv
`timescale 1ns / 1ps

module eld_decode (
  input  eld_pkg::state_t   state,
  input  eld_pkg::in_t      word,
  output eld_pkg::dec_out_t dec
);
  import eld_pkg::*;

  typedef enum logic [3:0] {
    BC_BYTE  = 4'b0001,
    BC_ESC   = 4'b0010,
    BC_CLOSE = 4'b0100,
    BC_ERROR = 4'b1000
  } body_cls_t;

  state_t     s;
  body_cls_t  cls;
  logic [7:0] term;
  logic [7:0] esc_val;
  logic [7:0] oct_nxt;
  res_t       r0;
  res_t       r1;
  logic [1:0] n;

  always_comb begin
    // start clears everything and opens a new literal with this byte
    if (word.start_req) begin
      s            = '0;
      s.phase      = PH_BODY;
      s.char_mode  = word.literal_kind;
    end else begin
      s = state;
    end

    term = s.char_mode ? CH_SQUOTE : CH_DQUOTE;
    if (word.ch == CH_NL || word.ch == CH_NUL) begin
      cls = BC_ERROR;
    end else if (word.ch == term) begin
      cls = BC_CLOSE;
    end else if (word.ch == CH_BSLASH) begin
      cls = BC_ESC;
    end else begin
      cls = BC_BYTE;
    end

    unique case (word.ch)
      CH_LOW_N: esc_val = CH_NL;
      CH_LOW_R: esc_val = CH_CR;
      CH_LOW_B: esc_val = CH_BS;
      CH_LOW_T: esc_val = CH_TAB;
      CH_LOW_F: esc_val = CH_FF;
      CH_LOW_V: esc_val = CH_VT;
      default:  esc_val = word.ch;
    endcase

    oct_nxt = {s.octal_acc[4:0], word.ch[2:0]};

    r0 = '0;
    r1 = '0;
    n  = 2'd0;

    unique case (s.phase)
      PH_BODY: begin
        unique case (cls)
          BC_ERROR: begin
            s.phase = PH_DONE;
            r0 = mk_res(s, KIND_ERROR, 8'h00);
            n  = 2'd1;
          end
          BC_CLOSE: begin
            s.phase = PH_DONE;
            r0 = mk_res(s, KIND_CLOSE, 8'h00);
            n  = 2'd1;
          end
          BC_ESC: begin
            s.phase = PH_ESC;
          end
          default: begin
            s  = emit_upd(s, word.ch);
            r0 = mk_res(s, KIND_BYTE, word.ch);
            n  = 2'd1;
          end
        endcase
      end
      PH_ESC: begin
        if (word.ch == CH_NUL) begin
          s.phase = PH_DONE;
          r0 = mk_res(s, KIND_ERROR, 8'h00);
          n  = 2'd1;
        end else if (is_octal(word.ch)) begin
          s.octal_acc = {5'd0, word.ch[2:0]};
          s.phase     = PH_OCT1;
        end else begin
          s.phase = PH_BODY;
          s  = emit_upd(s, esc_val);
          r0 = mk_res(s, KIND_BYTE, esc_val);
          n  = 2'd1;
        end
      end
      PH_OCT1, PH_OCT2: begin
        if (is_octal(word.ch)) begin
          s.octal_acc = oct_nxt;
          if (s.phase == PH_OCT1) begin
            s.phase = PH_OCT2;
          end else begin
            s.phase = PH_BODY;
            s  = emit_upd(s, oct_nxt);
            r0 = mk_res(s, KIND_BYTE, oct_nxt);
            n  = 2'd1;
          end
        end else begin
          // flush the pending escape, then treat ch as a body byte
          s.phase = PH_BODY;
          s  = emit_upd(s, s.octal_acc);
          r0 = mk_res(s, KIND_BYTE, s.octal_acc);
          n  = 2'd1;
          unique case (cls)
            BC_ERROR: begin
              s.phase = PH_DONE;
              r1 = mk_res(s, KIND_ERROR, 8'h00);
              n  = 2'd2;
            end
            BC_CLOSE: begin
              s.phase = PH_DONE;
              r1 = mk_res(s, KIND_CLOSE, 8'h00);
              n  = 2'd2;
            end
            BC_ESC: begin
              s.phase = PH_ESC;
            end
            default: begin
              s  = emit_upd(s, word.ch);
              r1 = mk_res(s, KIND_BYTE, word.ch);
              n  = 2'd2;
            end
          endcase
        end
      end
      default: begin
        // idle and done ignore the byte
      end
    endcase

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end

    dec.nxt = s;
    dec.n   = n;
    dec.r0  = r0;
    dec.r1  = r1;
  end

endmodule

### rtl/eld_result_fifo.sv
`timescale 1ns / 1ps

module eld_result_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  eld_pkg::res_t       push0,
  input  eld_pkg::res_t       push1,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output eld_pkg::res_t       out_word,
  output eld_pkg::fifo_stat_t stat
);
  import eld_pkg::*;

  res_t              mem_r [FifoDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LevelW-1:0] level_r, level_nxt;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (level_r != '0);
  assign out_word  = mem_r[rd_ptr_r];
  // room for a two-word burst regardless of the drain side
  assign space_ok  = (level_r <= LevelW'(FifoDepth - 2));
  assign stat.level = level_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push_n);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    level_nxt  = level_r + LevelW'(push_n) - LevelW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + PtrW'(1)] <= push1;
    end
  end

endmodule

### rtl/escape_literal_decoder.sv
`timescale 1ns / 1ps

// Escape decoder for the body of a quoted C literal.
// Input channel (in_valid / in_ready / in_word): one raw byte per word,
// starting with the byte after the opening quote; start_req marks that
// first byte and literal_kind picks string or character constant.
// Output channel (out_valid / out_ready / out_word): one result per word:
// a decoded byte, a normal close or an unterminated-literal error, with
// the packed character-constant value and the multi-character flag.
// Results are registered in the result queue before they reach out_word.
// Throughput: one byte per cycle while in_ready is high. A byte that
// flushes a pending octal escape yields two results, which leave the queue
// one word at a time; the four-word result queue absorbs that.
// Stall: while out_ready is low the queue fills; in_ready drops once fewer
// than two free slots remain, so no result is ever dropped.
// Reset: synchronous, active low; the decoder goes idle with all packing
// state cleared and the queue empty. Bytes arriving while idle or after a
// close without start_req are consumed and produce nothing.

module escape_literal_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  eld_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_ready,
  output eld_pkg::res_t out_word
);
  import eld_pkg::*;

  state_t     state_r;
  dec_out_t   dec;
  fifo_stat_t fstat;
  logic       space_ok;
  logic       in_fire;
  logic [1:0] push_n;

  assign in_ready = space_ok;
  assign in_fire  = in_valid && in_ready;
  assign push_n   = in_fire ? dec.n : 2'd0;

  // pure combinational decode of one byte against the current state
  eld_decode u_decode (
    .state (state_r),
    .word  (in_word),
    .dec   (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= state_t'{phase:      PH_IDLE,
                          octal_acc:  8'h00,
                          char_mode:  1'b0,
                          packed_acc: 32'h0,
                          seen_char:  1'b0,
                          multi_flag: 1'b0};
    end else if (in_fire) begin
      state_r <= dec.nxt;
    end
  end

  // result register / queue between decode and the output channel
  eld_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (dec.r0),
    .push1     (dec.r1),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .stat      (fstat)
  );

  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.level <= LevelW'(FifoDepth))
    else $error("result queue overflow");

  // only an octal flush can produce two results
  a_two_from_octal: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && dec.n == 2'd2) |->
      (!in_word.start_req && (state_r.phase == PH_OCT1 || state_r.phase == PH_OCT2)))
    else $error("two results outside an octal flush");

  // close and error always end a byte's results
  a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.result_kind != KIND_BYTE) |-> out_word.last)
    else $error("close or error word not marked last");

  // a closed literal stays closed until the next start
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_word.start_req && state_r.phase == PH_DONE) |->
      (dec.n == 2'd0 && dec.nxt.phase == PH_DONE))
    else $error("activity after literal closed");

endmodule
